### rtl/rwps_pkg.sv
// Package for the Ricker-wavelet point source: shared types, constants and the
// exponential lookup tables. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rwps_pkg;

  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 18;
  localparam logic [15:0] PPW_MIN     = 16'd256;
  localparam logic [19:0] PI2_Q16     = 20'd646814;
  localparam logic [19:0] ONE_Q15     = 20'd32768;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_SOURCE_X = 3'd0;
  localparam logic [2:0] REG_SOURCE_Y = 3'd1;
  localparam logic [2:0] REG_SOURCE_Z = 3'd2;
  localparam logic [2:0] REG_PPW      = 3'd3;
  localparam logic [2:0] REG_COURANT  = 3'd4;
  localparam logic [2:0] REG_TIME     = 3'd5;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  // exp(-k/16) in Q16, k = 0..16.
  function automatic logic [16:0] frac_exp(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd61565;
      5'd2:  v = 17'd57835;
      5'd3:  v = 17'd54331;
      5'd4:  v = 17'd51039;
      5'd5:  v = 17'd47947;
      5'd6:  v = 17'd45042;
      5'd7:  v = 17'd42313;
      5'd8:  v = 17'd39750;
      5'd9:  v = 17'd37341;
      5'd10: v = 17'd35079;
      5'd11: v = 17'd32954;
      5'd12: v = 17'd30957;
      5'd13: v = 17'd29081;
      5'd14: v = 17'd27319;
      5'd15: v = 17'd25664;
      5'd16: v = 17'd24109;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-n) in Q30, n = 0..15.
  function automatic logic [30:0] int_exp(input logic [3:0] n);
    logic [30:0] v;
    case (n)
      4'd0:  v = 31'd1073741824;
      4'd1:  v = 31'd395007542;
      4'd2:  v = 31'd145315154;
      4'd3:  v = 31'd53458457;
      4'd4:  v = 31'd19666267;
      4'd5:  v = 31'd7234815;
      4'd6:  v = 31'd2661540;
      4'd7:  v = 31'd979126;
      4'd8:  v = 31'd360200;
      4'd9:  v = 31'd132510;
      4'd10: v = 31'd48748;
      4'd11: v = 31'd17933;
      4'd12: v = 31'd6597;
      4'd13: v = 31'd2427;
      4'd14: v = 31'd893;
      4'd15: v = 31'd328;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/rwps_sqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on rwps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rwps_sqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rwps_pkg::pipe_ctl_t ctl,
  input  wire logic [63:0]        din,
  output logic                    vld_out,
  output logic [31:0]             root
);
  import rwps_pkg::*;

  logic [63:0] v_r   [0:SQRT_STAGES];
  logic [63:0] r_r   [0:SQRT_STAGES];
  logic        vld_r [0:SQRT_STAGES];

  always_comb begin
    v_r[0]   = din;
    r_r[0]   = 64'd0;
    vld_r[0] = ctl.vld;
  end

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [64:0] trial;
    logic [63:0] v_nxt, r_nxt;

    always_comb begin
      trial = {1'b0, r_r[j]} + {1'b0, BIT};
      if ({1'b0, v_r[j]} >= trial) begin
        v_nxt = v_r[j] - trial[63:0];
        r_nxt = (r_r[j] >> 1) + BIT;
      end else begin
        v_nxt = v_r[j];
        r_nxt = r_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[j+1] <= vld_r[j];
      end
      if (ctl.en) begin
        v_r[j+1] <= v_nxt;
        r_r[j+1] <= r_nxt;
      end
    end
  end

  assign vld_out = vld_r[SQRT_STAGES];
  assign root    = r_r[SQRT_STAGES][31:0];

endmodule
`default_nettype wire

### rtl/ricker_wavelet_point_source_top.sv
// Ricker-wavelet point source: z electric field of one grid point per transaction.
// The pipeline has 3 distance stages, 32 square root stages, 2 setup stages,
// 18 divider stages, 9 wavelet stages and the output register.
// Throughput is one transaction per cycle; the whole pipeline holds while the
// output register waits. Synchronous active-low reset clears valid bits and
// restores the configuration registers to their reset values.
// Depends on rwps_pkg and rwps_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module ricker_wavelet_point_source_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_field_z,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import rwps_pkg::*;

  logic signed [31:0] source_x_r, source_y_r, source_z_r;
  logic [15:0] ppw_r, courant_r;
  logic [23:0] time_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_x_r <= '0;
      source_y_r <= '0;
      source_z_r <= '0;
      ppw_r      <= 16'd5120;
      courant_r  <= 16'd18919;
      time_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_X: source_x_r <= cfg_data;
        REG_SOURCE_Y: source_y_r <= cfg_data;
        REG_SOURCE_Z: source_z_r <= cfg_data;
        REG_PPW:      ppw_r      <= cfg_data[15:0];
        REG_COURANT:  courant_r  <= cfg_data[15:0];
        REG_TIME:     time_r     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic signed [15:0] out_field_r;
  logic en;
  assign en = out_ready || !out_valid_r;
  assign in_ready = en;

  logic [15:0] ppw;
  logic [39:0] ct;
  assign ppw = (ppw_r < PPW_MIN) ? PPW_MIN : ppw_r;
  assign ct  = 40'(courant_r) * 40'(time_r);

  // Distance stages.
  logic v1_r, v2_r, v3_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic [61:0] qx_r, qy_r, qz_r;
  logic [63:0] sum_r;

  function automatic logic [61:0] sq_q30(input logic signed [32:0] d);
    logic [32:0] m;
    logic [65:0] p;
    m = d[32] ? 33'(-d) : 33'(d);
    p = 66'(m) * 66'(m);
    return p[63:2];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      dx_r  <= 33'(source_x_r) - 33'(in_point_x);
      dy_r  <= 33'(source_y_r) - 33'(in_point_y);
      dz_r  <= 33'(source_z_r) - 33'(in_point_z);
      qx_r  <= sq_q30(dx_r);
      qy_r  <= sq_q30(dy_r);
      qz_r  <= sq_q30(dz_r);
      sum_r <= 64'(qx_r) + 64'(qy_r) + 64'(qz_r);
    end
  end

  pipe_ctl_t sq_ctl;
  logic sq_vld;
  logic [31:0] sq_root;
  assign sq_ctl = '{en: en, vld: v3_r};

  rwps_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sq_ctl),
    .din     (sum_r),
    .vld_out (sq_vld),
    .root    (sq_root)
  );

  // Phase offset and division setup.
  logic vd_r, vp_r;
  logic signed [40:0] diff_r;
  logic [34:0] num_r;
  logic neg_p_r, ovf_p_r;
  logic [40:0] mag;
  logic [48:0] num_full;
  assign mag = diff_r[40] ? 41'(-diff_r) : 41'(diff_r);
  assign num_full = {mag[39:0], 8'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      vp_r <= 1'b0;
    end else if (en) begin
      vd_r <= sq_vld;
      vp_r <= vd_r;
    end
    if (en) begin
      diff_r  <= 41'(ct) - 41'(sq_root);
      // Quotients of 2^18 and above lie far outside the wavelet window.
      ovf_p_r <= num_full >= {15'd0, ppw, 18'd0};
      num_r   <= num_full[34:0];
      neg_p_r <= diff_r[40];
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic [34:0] rem_r [0:DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_r [0:DIV_STAGES];
  logic dv_r [0:DIV_STAGES];
  logic dneg_r [0:DIV_STAGES];
  logic dovf_r [0:DIV_STAGES];

  always_comb begin
    rem_r[0]  = num_r;
    quo_r[0]  = '0;
    dv_r[0]   = vp_r;
    dneg_r[0] = neg_p_r;
    dovf_r[0] = ovf_p_r;
  end

  for (genvar t = 0; t < DIV_STAGES; t++) begin : g_div
    localparam int unsigned SH = DIV_STAGES - 1 - t;
    logic [34:0] dsh;
    logic take;
    assign dsh  = 35'(ppw) << SH;
    assign take = rem_r[t] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[t+1] <= 1'b0;
      end else if (en) begin
        dv_r[t+1] <= dv_r[t];
      end
      if (en) begin
        rem_r[t+1]      <= take ? rem_r[t] - dsh : rem_r[t];
        quo_r[t+1]      <= quo_r[t] | (DIV_STAGES'(take) << SH);
        dneg_r[t+1]     <= dneg_r[t];
        dovf_r[t+1]     <= dovf_r[t];
      end
    end
  end

  // Wavelet stages.
  logic w1_r, w2_r, w3_r, w4_r, w5_r, w6_r, w7_r, w8_r, w9_r;
  logic in1_r, in2_r, in3_r, in4_r, in5_r, in6_r, in7_r, in8_r, in9_r;
  logic [16:0] ua_r;
  logic [33:0] usq_r;
  logic [53:0] p_r;
  logic [19:0] s4_r, s5_r, s6_r, s7_r;
  logic [28:0] prod_r;
  logic [16:0] tk_r, f_r;
  logic [47:0] ie_r;
  logic [28:0] e_r;
  logic [21:0] ga_r;
  logic gneg8_r, gneg9_r;
  logic [50:0] m_r;

  logic signed [19:0] qs, u;
  logic [19:0] qz;
  logic [54:0] p_rnd;
  logic [24:0] s_full;
  logic [4:0] kk;
  logic [16:0] t_hi, t_lo;
  logic [28:0] prod_rnd;
  logic [48:0] ie_rnd;
  logic signed [21:0] g;
  logic [51:0] m_rnd;
  logic [21:0] mr;
  logic signed [22:0] fld;

  always_comb begin
    qz     = {2'b00, quo_r[DIV_STAGES]};
    qs     = dneg_r[DIV_STAGES] ? -$signed(qz) : $signed(qz);
    u      = qs - $signed(ONE_Q15);
    p_rnd  = {1'b0, p_r} + (55'd1 << 29);
    s_full = p_rnd[54:30];
    kk     = {1'b0, s4_r[15:12]};
    t_hi   = frac_exp(kk);
    t_lo   = frac_exp(kk + 5'd1);
    prod_rnd = prod_r + 29'd2048;
    ie_rnd = {1'b0, ie_r} + (49'd1 << 17);
    g      = 22'sd65536 - $signed({1'b0, s7_r, 1'b0});
    m_rnd  = {1'b0, m_r} + (52'd1 << 29);
    mr     = m_rnd[51:30];
    fld    = gneg9_r ? -$signed({1'b0, mr}) : $signed({1'b0, mr});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {w1_r, w2_r, w3_r, w4_r, w5_r, w6_r, w7_r, w8_r, w9_r} <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      w1_r <= dv_r[DIV_STAGES];
      w2_r <= w1_r;
      w3_r <= w2_r;
      w4_r <= w3_r;
      w5_r <= w4_r;
      w6_r <= w5_r;
      w7_r <= w6_r;
      w8_r <= w7_r;
      w9_r <= w8_r;
      out_valid_r <= w9_r;
    end
    if (en) begin
      in1_r <= !dovf_r[DIV_STAGES] && (u > -20'sd131072) && (u < 20'sd131072);
      ua_r  <= u[19] ? 17'(-u) : 17'(u);
      in2_r <= in1_r;
      usq_r <= 34'(ua_r) * 34'(ua_r);
      in3_r <= in2_r;
      p_r   <= 54'(usq_r) * 54'(PI2_Q16);
      // Far tail: s of 16.0 and above gives zero.
      in4_r <= in3_r && (s_full < 25'(1 << 20));
      s4_r  <= s_full[19:0];
      in5_r <= in4_r;
      s5_r  <= s4_r;
      tk_r  <= t_hi;
      prod_r <= 29'(t_hi - t_lo) * 29'(s4_r[11:0]);
      in6_r <= in5_r;
      s6_r  <= s5_r;
      f_r   <= tk_r - 17'(prod_rnd[28:12]);
      in7_r <= in6_r;
      s7_r  <= s6_r;
      ie_r  <= 48'(int_exp(s6_r[19:16])) * 48'(f_r);
      in8_r <= in7_r;
      e_r   <= ie_rnd[46:18];
      gneg8_r <= g[21];
      ga_r  <= g[21] ? 22'(-g) : 22'(g);
      in9_r <= in8_r;
      gneg9_r <= gneg8_r;
      m_r   <= 51'(e_r) * 51'(ga_r);
      if (!in9_r) begin
        out_field_r <= '0;
      end else if (fld > 23'sd32767) begin
        out_field_r <= 16'sh7fff;
      end else if (fld < -23'sd32768) begin
        out_field_r <= -16'sd32768;
      end else begin
        out_field_r <= fld[15:0];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_field_z = out_field_r;

endmodule
`default_nettype wire

### dv/ricker_wavelet_point_source_top_test.sv
// Self-checking testbench for the Ricker-wavelet point source block.
// Depends on rwps_pkg and the RTL of ricker_wavelet_point_source_top; uses its own
// bit-exact field predictor, random handshake gaps and several register settings.
`timescale 1ns / 1ps
module ricker_wavelet_point_source_top_test;
  import rwps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [2:0] REG_UNUSED_6 = 3'd6;
  localparam logic [2:0] REG_UNUSED_7 = 3'd7;
  localparam logic [31:0] FRAC_TAB [17] = '{
    65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313, 39750,
    37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109};
  localparam logic [31:0] INT_TAB [16] = '{
    1073741824, 395007542, 145315154, 53458457, 19666267, 7234815,
    2661540, 979126, 360200, 132510, 48748, 17933, 6597, 2427, 893, 328};

  typedef struct {
    bit                 is_write;
    logic [2:0]         idx;
    logic [31:0]        data;
    logic signed [31:0] px, py, pz;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_field_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ricker_wavelet_point_source_top uut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Register copies used by the predictor, updated when a write is accepted.
  logic [31:0] src_x = 0, src_y = 0, src_z = 0;
  logic [15:0] ppw_reg = 16'd5120, courant_reg = 16'd18919;
  logic [23:0] tstep_reg = 0;

  // Register copies used by the stimulus generator to aim points at the wave.
  logic [31:0] gen_src_x = 0;
  logic [15:0] gen_ppw = 16'd5120, gen_courant = 16'd18919;
  logic [23:0] gen_tstep = 0;

  job_t pending_jobs[$];
  logic signed [15:0] expected_fields[$];
  int error_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [63:0] half_square(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [33:0] d;
    logic [63:0] m;
    d = a - b;
    m = (d < 0) ? 64'(-d) : 64'(d);
    return (m * m) >> 2;
  endfunction

  function automatic logic signed [15:0] ricker_field(input logic signed [31:0] px,
                                                      input logic signed [31:0] py,
                                                      input logic signed [31:0] pz);
    logic [63:0] rem, root, bitv, mag, q, ua, s, e, ga, m, ppw, f;
    logic signed [63:0] dist_q15, ct, diff, u, g, fld;
    logic [3:0] n, k;
    logic [11:0] r;
    rem = half_square(src_x, px) + half_square(src_y, py) + half_square(src_z, pz);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    dist_q15 = root;
    ct = 64'(courant_reg) * 64'(tstep_reg);
    diff = ct - dist_q15;
    ppw = (ppw_reg < PPW_MIN) ? 64'(PPW_MIN) : 64'(ppw_reg);
    mag = (diff < 0) ? -diff : diff;
    q = (mag << 8) / ppw;
    u = (diff < 0) ? -$signed(q) : $signed(q);
    u = u - 32768;
    fld = 0;
    if (u > -131072 && u < 131072) begin
      ua = (u < 0) ? -u : u;
      s = (ua * ua * 64'(PI2_Q16) + (64'd1 << 29)) >> 30;
      if (s < (64'd16 << 16)) begin
        n = s[19:16];
        k = s[15:12];
        r = s[11:0];
        f = FRAC_TAB[k] - (((FRAC_TAB[k] - FRAC_TAB[k + 1]) * r + 2048) >> 12);
        e = (64'(INT_TAB[n]) * f + (64'd1 << 17)) >> 18;
        g = 65536 - 2 * $signed(s);
        ga = (g < 0) ? -g : g;
        m = (e * ga + (64'd1 << 29)) >> 30;
        fld = (g < 0) ? -$signed(m) : $signed(m);
        if (fld > 32767) fld = 32767;
        if (fld < -32768) fld = -32768;
      end
    end
    return fld[15:0];
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // Driver: a register write waits until every expected field has come back.
  int in_gap = 0;
  always @(posedge clk) begin
    logic nxt_in_valid, nxt_cfg_valid;
    job_t j;
    nxt_in_valid = in_valid;
    nxt_cfg_valid = cfg_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_fields.push_back(ricker_field(in_point_x, in_point_y, in_point_z));
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_X: src_x = cfg_data;
          REG_SOURCE_Y: src_y = cfg_data;
          REG_SOURCE_Z: src_z = cfg_data;
          REG_PPW:      ppw_reg = cfg_data[15:0];
          REG_COURANT:  courant_reg = cfg_data[15:0];
          REG_TIME:     tstep_reg = cfg_data[23:0];
          default: ;
        endcase
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_jobs.size() > 0) begin
          j = pending_jobs[0];
          if (j.is_write) begin
            if (expected_fields.size() == 0 && !in_valid) begin
              void'(pending_jobs.pop_front());
              nxt_cfg_valid = 1'b1;
              cfg_index <= j.idx;
              cfg_data <= j.data;
            end
          end else begin
            void'(pending_jobs.pop_front());
            nxt_in_valid = 1'b1;
            in_point_x <= j.px;
            in_point_y <= j.py;
            in_point_z <= j.pz;
            in_gap = draw_gap();
          end
        end
      end
    end
    in_valid <= nxt_in_valid;
    cfg_valid <= nxt_cfg_valid;
  end

  // Monitor: compares each field transaction with the oldest expectation.
  int out_stall = 0;
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_fields.size() == 0) begin
          report_mismatch($sformatf("unexpected field %0d", out_field_z));
        end else begin
          want = expected_fields.pop_front();
          if (out_field_z !== want)
            report_mismatch($sformatf("field_z got %0d want %0d", out_field_z, want));
        end
        out_stall = draw_gap();
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_write(input logic [2:0] idx, input logic [31:0] data);
    job_t j;
    j.is_write = 1'b1;
    j.idx = idx;
    j.data = data;
    j.px = 0;
    j.py = 0;
    j.pz = 0;
    pending_jobs.push_back(j);
    case (idx)
      REG_SOURCE_X: gen_src_x = data;
      REG_PPW:      gen_ppw = data[15:0];
      REG_COURANT:  gen_courant = data[15:0];
      REG_TIME:     gen_tstep = data[23:0];
      default: ;
    endcase
  endtask

  task automatic add_point(input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
    job_t j;
    j.is_write = 1'b0;
    j.idx = '0;
    j.data = '0;
    j.px = x;
    j.py = y;
    j.pz = z;
    pending_jobs.push_back(j);
  endtask

  // Places a point along x at a distance where the wavelet is not negligible,
  // with small offsets in y and z around sy and sz, or a random point if too far.
  task automatic add_aimed_point(input logic [31:0] sy, input logic [31:0] sz);
    longint ct, ppw, target;
    int k;
    ppw = (gen_ppw < PPW_MIN) ? longint'(PPW_MIN) : longint'(gen_ppw);
    ct = longint'(gen_courant) * longint'(gen_tstep);
    k = int'($urandom_range(0, 800)) - 200;
    target = ct - ppw * 128 * k / 100;
    if (target < 0) target = -target;
    if (target * 2 > 64'sd2147483647) begin
      add_point($urandom, $urandom, $urandom);
    end else begin
      add_point(gen_src_x + 32'(target * 2),
                sy + $urandom_range(0, 15) - 8, sz + $urandom_range(0, 15) - 8);
    end
  endtask

  initial begin
    logic [31:0] sy, sz;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, then extreme coordinates of points and sources.
    add_point(0, 0, 0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_point(32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'h80000000, 32'h7FFFFFFF, 0);
    add_write(REG_SOURCE_X, 32'h7FFFFFFF);
    add_write(REG_SOURCE_Y, 32'h80000000);
    add_write(REG_SOURCE_Z, 32'h7FFFFFFF);
    add_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    add_write(REG_SOURCE_X, 0);
    add_write(REG_SOURCE_Y, 0);
    add_write(REG_SOURCE_Z, 0);
    // Courant above one, small points per wavelength and ignored indexes.
    add_write(REG_COURANT, 32'hFFFF);
    add_write(REG_PPW, 0);
    add_write(REG_TIME, 1);
    add_write(REG_UNUSED_6, 32'hFFFFFFFF);
    add_write(REG_UNUSED_7, 32'h12345678);
    add_point(0, 0, 0);
    add_point(32'h00010000, 0, 0);
    add_write(REG_PPW, 100);
    add_write(REG_COURANT, 32768);
    add_write(REG_TIME, 32'hFFFFFF);
    add_point(0, 0, 0);
    add_write(REG_PPW, 32'hFFFF);
    add_write(REG_COURANT, 0);
    add_write(REG_TIME, 0);
    add_point(0, 0, 0);
    add_point(32'hFFFF0000, 0, 0);
    add_write(REG_PPW, 5120);
    add_write(REG_COURANT, 18919);
    add_write(REG_TIME, 200);
    repeat (4) add_aimed_point(0, 0);

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 30; ph++) begin
      sy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65535) << 8;
      sz = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65535) << 8;
      add_write(REG_SOURCE_X, ($urandom_range(0, 3) == 0) ? $urandom : 0);
      add_write(REG_SOURCE_Y, sy);
      add_write(REG_SOURCE_Z, sz);
      case ($urandom_range(0, 5))
        0: add_write(REG_PPW, $urandom_range(0, 255));
        1: add_write(REG_PPW, 32'hFFFF);
        default: add_write(REG_PPW, $urandom_range(256, 65535));
      endcase
      case ($urandom_range(0, 5))
        0: add_write(REG_COURANT, 0);
        1: add_write(REG_COURANT, 32768);
        2: add_write(REG_COURANT, $urandom_range(32769, 65535));
        default: add_write(REG_COURANT, $urandom_range(1, 32767));
      endcase
      case ($urandom_range(0, 4))
        0: add_write(REG_TIME, 32'hFFFFFF);
        1: add_write(REG_TIME, $urandom);
        default: add_write(REG_TIME, $urandom_range(0, 4000));
      endcase
      if ($urandom_range(0, 4) == 0)
        add_write(3'($urandom_range(6, 7)), $urandom);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 9) < 7) add_aimed_point(sy, sz);
        else add_point($urandom, $urandom, $urandom);
      end
      // Pick at random whether the next stretch runs without idle cycles on both sides.
      no_idle = ($urandom_range(0, 3) == 0);
    end

    wait (pending_jobs.size() == 0 && !in_valid && !cfg_valid &&
          expected_fields.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_fields.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
